/* rtl/jfet_pkg.sv */
// Package for the J1939 fault event tracker.
// Holds PGN codes, register indexes, reset values, segment codes and the input beat type.
// No dependencies.
`default_nettype none

package jfet_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_GRACE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_WINDOW = 2'd2;

  localparam logic [15:0] GRACE_RST = 16'd5000;
  localparam logic [15:0] HOLD_RST = 16'd1500;
  localparam logic [31:0] POST_WINDOW_RST = 32'd300000;

  localparam logic [17:0] PGN_EEC1 = 18'd61444;
  localparam logic [17:0] PGN_DM1 = 18'd65226;
  localparam logic [7:0] PF_PDU2_MIN = 8'd240;
  localparam logic [7:0] BYTE_NA = 8'hFF;
  localparam logic [8:0] TORQUE_OFFSET = 9'd125;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] SEG_IDLE = 3'd0;
  localparam logic [2:0] SEG_START = 3'd1;
  localparam logic [2:0] SEG_ACTIVE = 3'd2;
  localparam logic [2:0] SEG_POST = 3'd3;
  localparam logic [2:0] SEG_POST_LAST = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] time_ms;
    logic [28:0] can_id;
    logic        is_extended;
    logic [3:0]  length;
    logic [63:0] payload;
  } in_beat_t;

endpackage

`default_nettype wire

/* rtl/j1939_fault_event_tracker.sv */
// J1939 fault event tracker top level: EEC1 and DM1 decode, snapshot per tick, event tracking.
// Depends on jfet_pkg.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid/in_ready    CAN frame or sample tick
//   out_     output     out_valid/out_ready  snapshot, one per tick
//   cfg_     input      cfg_wr_en            register write, no wait
//
// A beat is decoded from the input register during the cycle after its acceptance, and a
// tick's snapshot is registered when the tick leaves the input register; one beat per
// cycle is sustained while no tick waits on a full and stalled output register.
// Frames produce no snapshot and never wait on the output side.
// A tick waits in the input register only while the output register is full and stalled.
// Reset is synchronous and restores the register defaults and clears all decoded state.
`default_nettype none

module j1939_fault_event_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic                            in_kind,
  input  wire logic [31:0]                     in_time_ms,
  input  wire logic [28:0]                     in_can_id,
  input  wire logic                            in_is_extended,
  input  wire logic [3:0]                      in_length,
  input  wire logic [63:0]                     in_payload,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [2:0]                      out_segment,
  output      logic [15:0]                     out_rpm_eighths,
  output      logic                            out_rpm_valid,
  output      logic signed [8:0]               out_driver_torque,
  output      logic signed [8:0]               out_actual_torque,
  output      logic [1:0]                      out_torque_valid_bits,
  output      logic signed [8:0]               out_tq_delta,
  output      logic                            out_fault_active,
  output      logic                            out_fault_trigger,
  output      logic                            out_event_dtc_valid,
  output      logic [18:0]                     out_event_dtc_spn,
  output      logic [5:0]                      out_event_dtc_fmi_cm,
  input  wire logic                            cfg_wr_en,
  input  wire logic [jfet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jfet_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] grace_r;
  logic [15:0] hold_r;
  logic [31:0] post_window_r;

  jfet_pkg::in_beat_t beat_r;
  logic               beat_valid_r;

  logic [15:0]       speed_raw_r, speed_raw_nxt;
  logic              speed_ok_r, speed_ok_nxt;
  logic signed [8:0] demand_tq_r, demand_tq_nxt;
  logic signed [8:0] actual_tq_r, actual_tq_nxt;
  logic [1:0]        torque_ok_r, torque_ok_nxt;
  logic              diag_valid_r, diag_valid_nxt;
  logic [24:0]       diag_code_r, diag_code_nxt;
  logic [31:0]       diag_time_r, diag_time_nxt;
  logic              event_open_r, event_open_nxt;
  logic              post_started_r, post_started_nxt;
  logic [31:0]       post_end_r, post_end_nxt;
  logic              dtc_valid_r, dtc_valid_nxt;
  logic [24:0]       dtc_code_r, dtc_code_nxt;

  logic              out_valid_r;
  logic [2:0]        seg_r;
  logic              fault_r, trig_r;
  logic              ev_dtc_valid_r;
  logic [24:0]       ev_dtc_r;
  logic [15:0]       o_speed_r;
  logic              o_speed_ok_r;
  logic signed [8:0] o_demand_r, o_actual_r, o_gap_r;
  logic [1:0]        o_torque_ok_r;

  logic        out_free;
  logic        is_tick;
  logic        consume;
  logic [7:0]  pf;
  logic [17:0] pgn;
  logic        is_eec1, is_dm1;
  logic [7:0]  b0, b1, b2, b3, b4, b5;
  logic [15:0] spd;
  logic [31:0] since_diag;
  logic        fault, trig;
  logic [31:0] post_end_cand;
  logic [2:0]  seg;
  logic        dm1_ok;

  assign out_free = !out_valid_r || out_ready;
  assign is_tick  = beat_r.kind == jfet_pkg::KIND_TICK;
  assign consume  = beat_valid_r && (!is_tick || out_free);
  assign in_ready = !beat_valid_r || consume;

  assign pf  = beat_r.can_id[23:16];
  assign pgn = (pf < jfet_pkg::PF_PDU2_MIN) ? {beat_r.can_id[25:16], 8'h00}
                                            : beat_r.can_id[25:8];
  assign is_eec1 = beat_r.is_extended && (pgn == jfet_pkg::PGN_EEC1);
  assign is_dm1  = beat_r.is_extended && (pgn == jfet_pkg::PGN_DM1);

  assign b0  = beat_r.payload[7:0];
  assign b1  = beat_r.payload[15:8];
  assign b2  = beat_r.payload[23:16];
  assign b3  = beat_r.payload[31:24];
  assign b4  = beat_r.payload[39:32];
  assign b5  = beat_r.payload[47:40];
  assign spd = {b4, b3};

  assign dm1_ok = (beat_r.length >= 4'd6) &&
                  !((b2 == jfet_pkg::BYTE_NA) && (b3 == jfet_pkg::BYTE_NA) &&
                    (b4 == jfet_pkg::BYTE_NA) && (b5 == jfet_pkg::BYTE_NA));

  assign since_diag = beat_r.time_ms - diag_time_r;
  assign fault = diag_valid_r && (since_diag <= {16'd0, hold_r});
  assign trig  = fault && (beat_r.time_ms >= {16'd0, grace_r});
  assign post_end_cand = post_started_r ? post_end_r : (beat_r.time_ms + post_window_r);

  always_comb begin
    speed_raw_nxt    = speed_raw_r;
    speed_ok_nxt     = speed_ok_r;
    demand_tq_nxt    = demand_tq_r;
    actual_tq_nxt    = actual_tq_r;
    torque_ok_nxt    = torque_ok_r;
    diag_valid_nxt   = diag_valid_r;
    diag_code_nxt    = diag_code_r;
    diag_time_nxt    = diag_time_r;
    event_open_nxt   = event_open_r;
    post_started_nxt = post_started_r;
    post_end_nxt     = post_end_r;
    dtc_valid_nxt    = dtc_valid_r;
    dtc_code_nxt     = dtc_code_r;
    seg              = jfet_pkg::SEG_IDLE;

    if (!is_tick) begin
      if (is_eec1) begin
        speed_ok_nxt  = (beat_r.length >= 4'd5) && (spd != 16'hFFFF);
        speed_raw_nxt = speed_ok_nxt ? spd : 16'd0;
        torque_ok_nxt = 2'b00;
        demand_tq_nxt = 9'sd0;
        actual_tq_nxt = 9'sd0;
        if ((beat_r.length >= 4'd1) && (b0 != jfet_pkg::BYTE_NA)) begin
          demand_tq_nxt    = $signed({1'b0, b0} - jfet_pkg::TORQUE_OFFSET);
          torque_ok_nxt[0] = 1'b1;
        end
        if ((beat_r.length >= 4'd2) && (b1 != jfet_pkg::BYTE_NA)) begin
          actual_tq_nxt    = $signed({1'b0, b1} - jfet_pkg::TORQUE_OFFSET);
          torque_ok_nxt[1] = 1'b1;
        end
      end else if (is_dm1 && dm1_ok) begin
        diag_code_nxt  = {b5[7], b4[4:0], b4[7:5], b3, b2};
        diag_valid_nxt = 1'b1;
        diag_time_nxt  = beat_r.time_ms;
      end
    end else begin
      if (!event_open_r) begin
        if (trig) begin
          dtc_valid_nxt    = 1'b1;
          dtc_code_nxt     = diag_code_r;
          event_open_nxt   = 1'b1;
          post_started_nxt = 1'b0;
          post_end_nxt     = 32'd0;
          seg              = jfet_pkg::SEG_START;
        end
      end else if (trig) begin
        post_started_nxt = 1'b0;
        post_end_nxt     = 32'd0;
        seg              = jfet_pkg::SEG_ACTIVE;
      end else begin
        post_started_nxt = 1'b1;
        post_end_nxt     = post_end_cand;
        seg = (beat_r.time_ms >= post_end_cand) ? jfet_pkg::SEG_POST_LAST : jfet_pkg::SEG_POST;
      end
      if (seg == jfet_pkg::SEG_POST_LAST) begin
        event_open_nxt   = 1'b0;
        post_started_nxt = 1'b0;
        post_end_nxt     = 32'd0;
        dtc_valid_nxt    = 1'b0;
        dtc_code_nxt     = 25'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grace_r       <= jfet_pkg::GRACE_RST;
      hold_r        <= jfet_pkg::HOLD_RST;
      post_window_r <= jfet_pkg::POST_WINDOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        jfet_pkg::CFG_STARTUP_GRACE: grace_r <= cfg_wdata[15:0];
        jfet_pkg::CFG_FAULT_HOLD: hold_r <= cfg_wdata[15:0];
        jfet_pkg::CFG_POST_WINDOW: post_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else if (in_ready) begin
      beat_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r.kind        <= in_kind;
      beat_r.time_ms     <= in_time_ms;
      beat_r.can_id      <= in_can_id;
      beat_r.is_extended <= in_is_extended;
      beat_r.length      <= in_length;
      beat_r.payload     <= in_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_raw_r    <= 16'd0;
      speed_ok_r     <= 1'b0;
      demand_tq_r    <= 9'sd0;
      actual_tq_r    <= 9'sd0;
      torque_ok_r    <= 2'b00;
      diag_valid_r   <= 1'b0;
      diag_code_r    <= 25'd0;
      diag_time_r    <= 32'd0;
      event_open_r   <= 1'b0;
      post_started_r <= 1'b0;
      post_end_r     <= 32'd0;
      dtc_valid_r    <= 1'b0;
      dtc_code_r     <= 25'd0;
    end else if (consume) begin
      speed_raw_r    <= speed_raw_nxt;
      speed_ok_r     <= speed_ok_nxt;
      demand_tq_r    <= demand_tq_nxt;
      actual_tq_r    <= actual_tq_nxt;
      torque_ok_r    <= torque_ok_nxt;
      diag_valid_r   <= diag_valid_nxt;
      diag_code_r    <= diag_code_nxt;
      diag_time_r    <= diag_time_nxt;
      event_open_r   <= event_open_nxt;
      post_started_r <= post_started_nxt;
      post_end_r     <= post_end_nxt;
      dtc_valid_r    <= dtc_valid_nxt;
      dtc_code_r     <= dtc_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= consume && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && is_tick) begin
      seg_r          <= seg;
      fault_r        <= fault;
      trig_r         <= trig;
      ev_dtc_valid_r <= (seg == jfet_pkg::SEG_START) ? 1'b1 : dtc_valid_r;
      ev_dtc_r       <= (seg == jfet_pkg::SEG_START) ? diag_code_r
                        : (dtc_valid_r ? dtc_code_r : 25'd0);
      o_speed_r      <= speed_raw_r;
      o_speed_ok_r   <= speed_ok_r;
      o_demand_r     <= demand_tq_r;
      o_actual_r     <= actual_tq_r;
      o_torque_ok_r  <= torque_ok_r;
      o_gap_r        <= (torque_ok_r == 2'b11) ? (demand_tq_r - actual_tq_r) : 9'sd0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_segment           = seg_r;
  assign out_rpm_eighths       = o_speed_r;
  assign out_rpm_valid         = o_speed_ok_r;
  assign out_driver_torque     = o_demand_r;
  assign out_actual_torque     = o_actual_r;
  assign out_torque_valid_bits = o_torque_ok_r;
  assign out_tq_delta          = o_gap_r;
  assign out_fault_active      = fault_r;
  assign out_fault_trigger     = trig_r;
  assign out_event_dtc_valid   = ev_dtc_valid_r;
  assign out_event_dtc_spn     = ev_dtc_r[18:0];
  assign out_event_dtc_fmi_cm  = ev_dtc_r[24:19];

endmodule

`default_nettype wire

/* rtl/jfet_checker.sv */
// Port-level checker for the J1939 fault event tracker, bound to the top level.
// Depends on jfet_pkg and j1939_fault_event_tracker.
`default_nettype none

module jfet_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        out_segment,
  input wire logic [15:0]       out_rpm_eighths,
  input wire logic [1:0]        out_torque_valid_bits,
  input wire logic signed [8:0] out_tq_delta,
  input wire logic              out_fault_active,
  input wire logic              out_fault_trigger,
  input wire logic              out_event_dtc_valid,
  input wire logic [18:0]       out_event_dtc_spn,
  input wire logic [5:0]        out_event_dtc_fmi_cm
);

  a_trig_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault_trigger |-> out_fault_active)
    else $error("trigger reported without an active fault");

  a_start_has_dtc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_segment == jfet_pkg::SEG_START) |->
      out_event_dtc_valid && out_fault_trigger)
    else $error("event start without trigger or latched DTC");

  a_idle_no_dtc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_segment == jfet_pkg::SEG_IDLE) |->
      !out_event_dtc_valid && (out_event_dtc_spn == 19'd0) && (out_event_dtc_fmi_cm == 6'd0))
    else $error("DTC reported while no event is open");

  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_torque_valid_bits != 2'b11) |-> (out_tq_delta == 9'sd0))
    else $error("torque gap nonzero without both torques valid");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_segment) && $stable(out_rpm_eighths))
    else $error("stalled output beat changed");

endmodule

bind j1939_fault_event_tracker jfet_checker u_jfet_checker (.*);

`default_nettype wire
